/* rtl/prf_pkg.sv */
// Shared constants and config register codes for the page replacement unit.
// No dependencies; imported by prf_cell and page_replacement_fifo_lru.
package prf_pkg;

	// fixed field widths
	localparam int ADDR_W = 27;
	localparam int PAGE_W = 19;
	localparam int SLOT_W = 6;
	localparam int CNT_W  = 32;

	// config port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int OFF_W      = 4;
	localparam int LIMIT_W    = 7;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_BITS = 2'd0,
		REG_FRAME_LIMIT = 2'd1,
		REG_POLICY      = 2'd2
	} cfg_reg_t;

	// replacement policy codes
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	// page offset bounds and reset values
	localparam logic [OFF_W-1:0]   OFF_MIN       = 4'd8;
	localparam logic [OFF_W-1:0]   OFF_MAX       = 4'd13;
	localparam logic [OFF_W-1:0]   OFF_RESET     = 4'd12;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 7'd64;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

/* rtl/page_replacement_fifo_lru.sv */
// Top level of the FIFO/LRU page replacement unit: config, control, cell row.
// Depends on prf_pkg and prf_cell.
//
// Usage: one logical address per input beat (in_valid/in_ready). The page
// number is the address shifted right by offset_bits (clamped to 8..13) and
// is looked up in a fully associative row of MAX_FRAMES cells kept in age
// order, cell 0 being the next victim. Each result beat (out_valid/out_ready)
// carries the page, hit, eviction, frame slot and three saturating counters.
// Timing: the address is registered at the accepting edge (stage 1), the
// cell row is compared against it and the results are registered (stage
// 2), and the row is updated as stage 2 fires, which also loads the output
// register. No new beat is taken while the previous one is in stage 1, or in
// stage 2 without firing, since the next compare must see the updated row.
// Reset empties the row (occupancy zero), clears the counters and sets
// offset_bits 12, frame_limit 64, FIFO policy. Config writes are taken at
// any edge with cfg_we high and are meant for idle periods only.
// When the receiver stalls the result is held; one more beat may enter the
// compare stage, then in_ready stays low until the result is taken.
module page_replacement_fifo_lru #(
	parameter int MAX_FRAMES   = 64,
	parameter int ADDRESS_BITS = 27
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [prf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [prf_pkg::ADDR_W-1:0]    logical_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prf_pkg::PAGE_W-1:0]    page_number,
	output logic                          hit,
	output logic                          replaced,
	output logic [prf_pkg::PAGE_W-1:0]    evicted_page,
	output logic [prf_pkg::SLOT_W-1:0]    frame_slot,
	output logic [prf_pkg::CNT_W-1:0]     reference_count,
	output logic [prf_pkg::CNT_W-1:0]     fault_count,
	output logic [prf_pkg::CNT_W-1:0]     replacement_count
);
	import prf_pkg::*;

	localparam int IW = $clog2(MAX_FRAMES);
	localparam int OW = $clog2(MAX_FRAMES + 1);
	localparam int LW = (OW > LIMIT_W) ? OW : LIMIT_W;
	localparam logic [LW-1:0] MAX_L = LW'(MAX_FRAMES);

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	// config registers
	logic [OFF_W-1:0]   offset_bits_q;
	logic [LIMIT_W-1:0] frame_limit_q;
	logic               policy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= OFF_RESET;
			frame_limit_q <= LIMIT_RESET;
			policy_q      <= POLICY_FIFO;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_OFFSET_BITS: offset_bits_q <= cfg_wdata[OFF_W-1:0];
				REG_FRAME_LIMIT: frame_limit_q <= cfg_wdata[LIMIT_W-1:0];
				REG_POLICY:      policy_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// clamped offset and frame limit
	logic [OFF_W-1:0] sh;
	logic [LW-1:0]    lim;

	always_comb begin
		if (offset_bits_q < OFF_MIN)      sh = OFF_MIN;
		else if (offset_bits_q > OFF_MAX) sh = OFF_MAX;
		else                              sh = offset_bits_q;
		if (frame_limit_q == '0)               lim = LW'(1);
		else if (LW'(frame_limit_q) > MAX_L)   lim = MAX_L;
		else                                   lim = LW'(frame_limit_q);
	end

	// page number from the masked address
	logic [ADDR_W-1:0] amask;
	logic [ADDR_W-1:0] addr_shifted;

	always_comb begin
		for (int i = 0; i < ADDR_W; i++) begin
			amask[i] = (i < ADDRESS_BITS);
		end
		addr_shifted = (logical_address & amask) >> sh;
	end

	// pipeline control
	logic s1_v_q, s2_v_q, out_v_q;
	logic s2_go;

	assign s2_go     = !out_v_q || out_ready;
	assign in_ready  = !s1_v_q && (!s2_v_q || s2_go);
	assign out_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			s1_v_q <= in_valid && in_ready;
			if (s1_v_q)
				s2_v_q <= 1'b1;
			else if (s2_go)
				s2_v_q <= 1'b0;
			if (s2_v_q && s2_go)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	// stage 1: registered page number
	logic [PAGE_W-1:0] page_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			page_s1 <= addr_shifted[PAGE_W-1:0];
	end

	// cell row
	logic [PAGE_W-1:0] cell_page [MAX_FRAMES];
	logic [IW-1:0]     cell_slot [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] match;
	logic [OW-1:0]     occ_q;

	logic              upd_en, shift_en;
	logic [IW-1:0]     start, wi, new_slot;
	logic [PAGE_W-1:0] page_s2;

	for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
		logic [PAGE_W-1:0] nxt_page;
		logic [IW-1:0]     nxt_slot;
		if (k == MAX_FRAMES - 1) begin : g_last
			assign nxt_page = page_s2;
			assign nxt_slot = new_slot;
		end else begin : g_mid
			assign nxt_page = cell_page[k+1];
			assign nxt_slot = cell_slot[k+1];
		end
		prf_cell #(
			.IDX (k),
			.IW  (IW),
			.OW  (OW)
		) u_cell (
			.clk       (clk),
			.page_cmp  (page_s1),
			.occ       (occ_q),
			.upd_en    (upd_en),
			.shift_en  (shift_en),
			.start     (start),
			.wi        (wi),
			.new_page  (page_s2),
			.new_slot  (new_slot),
			.next_page (nxt_page),
			.next_slot (nxt_slot),
			.page_q    (cell_page[k]),
			.slot_q    (cell_slot[k]),
			.match     (match[k])
		);
	end

	// match reduction: at most one live entry holds a given page
	logic          any_hit;
	logic [IW-1:0] hit_pos, hit_slot;

	always_comb begin
		any_hit  = |match;
		hit_pos  = '0;
		hit_slot = '0;
		for (int k = 0; k < MAX_FRAMES; k++) begin
			hit_pos  = hit_pos  | ({IW{match[k]}} & IW'(k));
			hit_slot = hit_slot | ({IW{match[k]}} & cell_slot[k]);
		end
	end

	// stage 2: compare results
	logic              hit_s2;
	logic [IW-1:0]     pos_s2, slot_s2, slot0_s2;
	logic [PAGE_W-1:0] victim_s2;

	always_ff @(posedge clk) begin
		if (s1_v_q) begin
			page_s2   <= page_s1;
			hit_s2    <= any_hit;
			pos_s2    <= hit_pos;
			slot_s2   <= hit_slot;
			slot0_s2  <= cell_slot[0];
			victim_s2 <= cell_page[0];
		end
	end

	// update decision
	logic fire, full, fill, evict, lru_hit;

	always_comb begin
		fire     = s2_v_q && s2_go;
		full     = LW'(occ_q) >= lim;
		fill     = !hit_s2 && !full;
		evict    = !hit_s2 && full;
		lru_hit  = hit_s2 && (policy_q == POLICY_LRU);
		upd_en   = fire && (fill || evict || lru_hit);
		shift_en = evict || lru_hit;
		start    = lru_hit ? pos_s2 : '0;
		wi       = fill ? occ_q[IW-1:0] : IW'(occ_q - 1'b1);
		if (hit_s2)    new_slot = slot_s2;
		else if (fill) new_slot = occ_q[IW-1:0];
		else           new_slot = slot0_s2;
	end

	// occupancy and counters
	logic [CNT_W-1:0] refs_q, faults_q, evicts_q;
	logic [CNT_W-1:0] refs_nx, faults_nx, evicts_nx;

	always_comb begin
		refs_nx   = sat_inc(refs_q);
		faults_nx = hit_s2 ? faults_q : sat_inc(faults_q);
		evicts_nx = evict ? sat_inc(evicts_q) : evicts_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			refs_q   <= '0;
			faults_q <= '0;
			evicts_q <= '0;
		end else if (fire) begin
			if (fill)
				occ_q <= occ_q + 1'b1;
			refs_q   <= refs_nx;
			faults_q <= faults_nx;
			evicts_q <= evicts_nx;
		end
	end

	// output register
	logic              hit_q, replaced_q;
	logic [PAGE_W-1:0] page_q, evicted_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  refs_out_q, faults_out_q, evicts_out_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			page_q       <= page_s2;
			hit_q        <= hit_s2;
			replaced_q   <= evict;
			evicted_q    <= evict ? victim_s2 : '0;
			slot_q       <= SLOT_W'(new_slot);
			refs_out_q   <= refs_nx;
			faults_out_q <= faults_nx;
			evicts_out_q <= evicts_nx;
		end
	end

	assign page_number       = page_q;
	assign hit               = hit_q;
	assign replaced          = replaced_q;
	assign evicted_page      = evicted_q;
	assign frame_slot        = slot_q;
	assign reference_count   = refs_out_q;
	assign fault_count       = faults_out_q;
	assign replacement_count = evicts_out_q;

endmodule

/* rtl/prf_cell.sv */
// One entry of the age-ordered resident page row: page tag, frame slot, match.
// Depends on prf_pkg; instantiated once per frame by page_replacement_fifo_lru.
module prf_cell #(
	parameter int IDX = 0,
	parameter int IW  = 6,
	parameter int OW  = 7
) (
	input  logic                       clk,
	input  logic [prf_pkg::PAGE_W-1:0] page_cmp,
	input  logic [OW-1:0]              occ,
	input  logic                       upd_en,
	input  logic                       shift_en,
	input  logic [IW-1:0]              start,
	input  logic [IW-1:0]              wi,
	input  logic [prf_pkg::PAGE_W-1:0] new_page,
	input  logic [IW-1:0]              new_slot,
	input  logic [prf_pkg::PAGE_W-1:0] next_page,
	input  logic [IW-1:0]              next_slot,
	output logic [prf_pkg::PAGE_W-1:0] page_q,
	output logic [IW-1:0]              slot_q,
	output logic                       match
);
	import prf_pkg::*;

	localparam logic [IW-1:0] K_IDX = IW'(IDX);
	localparam logic [OW-1:0] K_OCC = OW'(IDX);

	// entry is live only below occupancy
	assign match = (K_OCC < occ) && (page_q == page_cmp);

	// load the new page at the write index, or take the neighbor's entry
	always_ff @(posedge clk) begin
		if (upd_en) begin
			if (K_IDX == wi) begin
				page_q <= new_page;
				slot_q <= new_slot;
			end else if (shift_en && (K_IDX >= start) && (K_IDX < wi)) begin
				page_q <= next_page;
				slot_q <= next_slot;
			end
		end
	end

endmodule
